// ===== rtl/core/ordered_free_list_with_key_delete_macros.svh =====
// assertion macros for the ordered free list checker
// expects clk and rst in scope at the point of use
`ifndef ORDERED_FREE_LIST_WITH_KEY_DELETE_MACROS_SVH
`define ORDERED_FREE_LIST_WITH_KEY_DELETE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define OFL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define OFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ofl_pkg.sv =====
// shared types and constants for the ordered free list
// no dependencies
package ofl_pkg;

  localparam int LIST_DEPTH  = 16;
  localparam int BLOCK_BITS  = 10;
  localparam int STATUS_BITS = 3;
  localparam int ACTION_BITS = 2;
  localparam int COUNT_BITS  = $clog2(LIST_DEPTH + 1);

  localparam logic [ACTION_BITS-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_LOOKUP = 2'd2;

  localparam logic [STATUS_BITS-1:0] DELAYED_CODE_RESET = 3'd1;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

// ===== rtl/core/ofl_ctrl.sv =====
// controller for the ordered free list: accept, execute, output handshake
// depends on ofl_pkg
module ofl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output ofl_pkg::cmd_t cmd
);

  ofl_pkg::state_t state, state_next;
  logic            out_valid_next;
  logic            slot_free;

  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ofl_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ofl_pkg::ST_IDLE: begin
        if (in_valid) state_next = ofl_pkg::ST_EXEC;
      end
      ofl_pkg::ST_EXEC: begin
        if (slot_free) state_next = ofl_pkg::ST_IDLE;
      end
      default: state_next = ofl_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    in_stall = 1'b1;
    unique case (state)
      ofl_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ofl_pkg::ST_EXEC: begin
        cmd.exec = slot_free;
      end
      default: in_stall = 1'b1;
    endcase
    if (cmd.exec) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// ===== rtl/core/ofl_dpath.sv =====
// datapath for the ordered free list: entry row, per-entry match, shift-up delete
// depends on ofl_pkg
module ofl_dpath (
  input  logic                            clk,
  input  logic                            rst,
  input  ofl_pkg::cmd_t                   cmd,
  input  logic [ofl_pkg::ACTION_BITS-1:0] action,
  input  logic [ofl_pkg::BLOCK_BITS-1:0]  block_number,
  input  logic [ofl_pkg::STATUS_BITS-1:0] block_status,
  input  logic                            cfg_write,
  input  logic [ofl_pkg::STATUS_BITS-1:0] cfg_data,
  output logic                            found,
  output logic                            overflow,
  output logic                            list_empty,
  output logic [ofl_pkg::BLOCK_BITS-1:0]  head_block,
  output logic                            any_delayed
);

  localparam int N = ofl_pkg::LIST_DEPTH;

  logic [ofl_pkg::BLOCK_BITS-1:0]  entry_block  [N];
  logic [ofl_pkg::STATUS_BITS-1:0] entry_status [N];
  logic [ofl_pkg::COUNT_BITS-1:0]  entry_count;
  logic [ofl_pkg::STATUS_BITS-1:0] delayed_code;

  logic [ofl_pkg::ACTION_BITS-1:0] action_q;
  logic [ofl_pkg::BLOCK_BITS-1:0]  key_q;
  logic [ofl_pkg::STATUS_BITS-1:0] status_q;

  logic [N-1:0] valid;
  logic [N-1:0] match;
  logic [N-1:0] first;
  logic [N-1:0] shift_mask;
  logic [N-1:0] ins_sel;
  logic [N-1:0] delayed_hit;
  logic         hit;
  logic         full;
  logic         do_insert;
  logic         do_delete;

  // latched word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_q <= action;
      key_q    <= block_number;
      status_q <= block_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delayed_code <= ofl_pkg::DELAYED_CODE_RESET;
    end else if (cfg_write) begin
      delayed_code <= cfg_data;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cmp
      assign valid[gi]       = entry_count > ofl_pkg::COUNT_BITS'(gi);
      assign match[gi]       = valid[gi] && (entry_block[gi] == key_q);
      assign ins_sel[gi]     = entry_count == ofl_pkg::COUNT_BITS'(gi);
      assign delayed_hit[gi] = valid[gi] && (entry_status[gi] == delayed_code);
    end
  endgenerate

  // isolate first match from the head; entries at or behind it shift up
  assign first      = match & (~match + N'(1));
  assign shift_mask = ~(first - N'(1));
  assign hit        = |match;
  assign full       = entry_count == ofl_pkg::COUNT_BITS'(N);
  assign do_insert  = cmd.exec && (action_q == ofl_pkg::ACT_INSERT) && !full;
  assign do_delete  = cmd.exec && (action_q == ofl_pkg::ACT_DELETE) && hit;

  generate
    for (gi = 0; gi < N; gi++) begin : g_entry
      if (gi < N - 1) begin : g_mid
        always_ff @(posedge clk) begin
          if (do_insert && ins_sel[gi]) begin
            entry_block[gi]  <= key_q;
            entry_status[gi] <= status_q;
          end else if (do_delete && shift_mask[gi]) begin
            entry_block[gi]  <= entry_block[gi+1];
            entry_status[gi] <= entry_status[gi+1];
          end
        end
      end else begin : g_last
        // last slot falls out of range on delete via the count
        always_ff @(posedge clk) begin
          if (do_insert && ins_sel[gi]) begin
            entry_block[gi]  <= key_q;
            entry_status[gi] <= status_q;
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (do_insert) begin
      entry_count <= entry_count + ofl_pkg::COUNT_BITS'(1);
    end else if (do_delete) begin
      entry_count <= entry_count - ofl_pkg::COUNT_BITS'(1);
    end
  end

  // per-word flags, found reflects the list before the update
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      found    <= hit;
      overflow <= (action_q == ofl_pkg::ACT_INSERT) && full;
    end
  end

  // list summary straight from the entry registers
  assign list_empty  = entry_count == '0;
  assign head_block  = list_empty ? '0 : entry_block[0];
  assign any_delayed = |delayed_hit;

endmodule

// ===== rtl/core/ordered_free_list_with_key_delete.sv =====
// ordered free list of buffer blocks with delete by block number
// the input word is latched in idle, the result word is registered in exec once the result slot is free
// one word at a time, set by the accept/execute controller: no new word is taken while one waits in exec
// a new word is taken while the previous result still waits for the consumer
// rst (synchronous, active high) empties the list, delayed_code returns to 1
module ordered_free_list_with_key_delete (
  input  logic                            clk,
  input  logic                            rst,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ofl_pkg::ACTION_BITS-1:0] action,
  input  logic [ofl_pkg::BLOCK_BITS-1:0]  block_number,
  input  logic [ofl_pkg::STATUS_BITS-1:0] block_status,
  // delayed_code register write
  input  logic                            cfg_write,
  input  logic [ofl_pkg::STATUS_BITS-1:0] cfg_data,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            found,
  output logic                            overflow,
  output logic                            list_empty,
  output logic [ofl_pkg::BLOCK_BITS-1:0]  head_block,
  output logic                            any_delayed
);

  // load latches the word, exec updates the entry row and the result flags
  ofl_pkg::cmd_t cmd;

  // controller: idle accepts, exec waits for a free result register
  ofl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath: all entries compared in parallel, first match picked from the head,
  // entries behind it close the gap in one step; head, empty and delayed summary
  // are read from the entry registers, which only change when the result slot is free
  ofl_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .action       (action),
    .block_number (block_number),
    .block_status (block_status),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .found        (found),
    .overflow     (overflow),
    .list_empty   (list_empty),
    .head_block   (head_block),
    .any_delayed  (any_delayed)
  );

endmodule

// ===== rtl/core/ofl_checker.sv =====
// port-level checks for the ordered free list
// depends on ofl_pkg and the macros header; bound to the top level
`include "ordered_free_list_with_key_delete_macros.svh"

module ofl_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           found,
  input logic                           overflow,
  input logic                           list_empty,
  input logic [ofl_pkg::BLOCK_BITS-1:0] head_block,
  input logic                           any_delayed
);

  `OFL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled word dropped")

  `OFL_ASSERT_SAME(a_empty_head, out_valid && list_empty, head_block == '0, "head not zero when empty")

  `OFL_ASSERT_SAME(a_empty_delayed, out_valid && list_empty, !any_delayed, "delayed flag on empty list")

  `OFL_ASSERT_SAME(a_overflow_full, out_valid && overflow, !list_empty && !found || !list_empty, "overflow with empty list")

  `OFL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second word taken back to back")

endmodule

bind ordered_free_list_with_key_delete ofl_checker u_ofl_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .found       (found),
  .overflow    (overflow),
  .list_empty  (list_empty),
  .head_block  (head_block),
  .any_delayed (any_delayed)
);

// ===== verif/tb_ordered_free_list_with_key_delete.sv =====
// self-checking testbench for the ordered free list with delete by block number
// depends on ofl_pkg and the ordered_free_list_with_key_delete rtl only
`timescale 1ns / 1ps

module tb_ordered_free_list_with_key_delete;

  // action code that the block treats like a lookup
  localparam logic [ofl_pkg::ACTION_BITS-1:0] ACT_UNUSED = 2'd3;
  localparam int IDLE_PCT_NORMAL = 37;
  localparam int RX_HOLD_CYCLES  = 80;
  localparam int SETTLE_CYCLES   = 8;    // leave a margin for the block to settle
  localparam int NUM_PHASES      = 8;
  localparam int BURSTS          = 5;
  localparam int BURST_LEN       = 40;
  localparam int POOL_SIZE       = 10;

  typedef struct packed {
    logic [ofl_pkg::ACTION_BITS-1:0] action;
    logic [ofl_pkg::BLOCK_BITS-1:0]  blk;
    logic [ofl_pkg::STATUS_BITS-1:0] sts;
  } list_req_t;

  typedef struct packed {
    logic                           found;
    logic                           overflow;
    logic                           list_empty;
    logic [ofl_pkg::BLOCK_BITS-1:0] head;
    logic                           any_delayed;
  } list_result_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #4 clk = ~clk;

  // block ports, the inputs all known from time zero
  logic                            in_valid     = 1'b0;
  logic                            in_stall;
  logic [ofl_pkg::ACTION_BITS-1:0] action       = ofl_pkg::ACT_LOOKUP;
  logic [ofl_pkg::BLOCK_BITS-1:0]  block_number = '0;
  logic [ofl_pkg::STATUS_BITS-1:0] block_status = '0;
  logic                            cfg_write    = 1'b0;
  logic [ofl_pkg::STATUS_BITS-1:0] cfg_data     = '0;
  logic                            out_valid;
  logic                            out_stall    = 1'b0;
  logic                            found;
  logic                            overflow;
  logic                            list_empty;
  logic [ofl_pkg::BLOCK_BITS-1:0]  head_block;
  logic                            any_delayed;

  ordered_free_list_with_key_delete u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .block_number (block_number),
    .block_status (block_status),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .overflow     (overflow),
    .list_empty   (list_empty),
    .head_block   (head_block),
    .any_delayed  (any_delayed)
  );

  // words waiting to be offered, and results owed by the block
  list_req_t    pending_words[$];
  list_result_t owed_results[$];

  // shadow copy of the free list, updated on every accepted word
  logic [ofl_pkg::BLOCK_BITS-1:0]  shadow_blk [ofl_pkg::LIST_DEPTH];
  logic [ofl_pkg::STATUS_BITS-1:0] shadow_sts [ofl_pkg::LIST_DEPTH];
  int                              shadow_cnt = 0;
  logic [ofl_pkg::STATUS_BITS-1:0] shadow_delayed_code = ofl_pkg::DELAYED_CODE_RESET;

  // traffic control, written by the sequencer on the falling edge
  int idle_pct = IDLE_PCT_NORMAL;
  int hold_seq = 0;

  int err_cnt       = 0;
  int n_words_in    = 0;
  int n_results     = 0;
  int n_overflow    = 0;
  int n_delete_hits = 0;
  int n_cfg_writes  = 0;

  logic [ofl_pkg::BLOCK_BITS-1:0] key_pool [POOL_SIZE];

  // apply one word to the shadow list and return the result it should give
  function automatic list_result_t apply_list_op(list_req_t w);
    list_result_t r;
    int pos;
    int i;
    pos = shadow_cnt;
    for (i = shadow_cnt - 1; i >= 0; i--) begin
      if (shadow_blk[i] == w.blk) pos = i;   // first match from the head wins
    end
    r = '0;
    r.found = (pos < shadow_cnt);
    if (w.action == ofl_pkg::ACT_INSERT) begin
      if (shadow_cnt >= ofl_pkg::LIST_DEPTH) begin
        r.overflow = 1'b1;
        n_overflow++;
      end else begin
        shadow_blk[shadow_cnt] = w.blk;
        shadow_sts[shadow_cnt] = w.sts;
        shadow_cnt++;
      end
    end else if (w.action == ofl_pkg::ACT_DELETE && r.found) begin
      // entries behind the match close up the gap
      for (i = pos; i + 1 < shadow_cnt; i++) begin
        shadow_blk[i] = shadow_blk[i + 1];
        shadow_sts[i] = shadow_sts[i + 1];
      end
      shadow_cnt--;
      n_delete_hits++;
    end
    r.list_empty = (shadow_cnt == 0);
    r.head = (shadow_cnt > 0) ? shadow_blk[0] : '0;
    for (i = 0; i < shadow_cnt; i++) begin
      if (shadow_sts[i] == shadow_delayed_code) r.any_delayed = 1'b1;
    end
    return r;
  endfunction

  // driver: offers pending words, holds a stalled word steady
  always @(posedge clk) begin : drive_proc
    list_req_t cur;
    list_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        cur = {action, block_number, block_status};
        owed_results.push_back(apply_list_op(cur));
        n_words_in++;
      end
      // a new word only once the current one is gone
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = pending_words.pop_front();
          in_valid     <= 1'b1;
          action       <= nxt.action;
          block_number <= nxt.blk;
          block_status <= nxt.sts;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each accepted result word against the oldest one owed
  int hold_left = 0;
  int hold_seen = 0;
  always @(posedge clk) begin : check_proc
    list_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $error("result word arrived with nothing owed");
          err_cnt++;
        end else begin
          want = owed_results.pop_front();
          n_results++;
          if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            err_cnt++;
          end
          if (overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, overflow);
            err_cnt++;
          end
          if (list_empty !== want.list_empty) begin
            $error("list_empty: expected %0d, got %0d", want.list_empty, list_empty);
            err_cnt++;
          end
          if (head_block !== want.head) begin
            $error("head_block: expected %0d, got %0d", want.head, head_block);
            err_cnt++;
          end
          if (any_delayed !== want.any_delayed) begin
            $error("any_delayed: expected %0d, got %0d", want.any_delayed, any_delayed);
            err_cnt++;
          end
        end
      end
      // long hold-off on request, otherwise random back-pressure
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (hold_seq != hold_seen) begin
        hold_seen <= hold_seq;
        hold_left <= RX_HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  task automatic push_word(logic [ofl_pkg::ACTION_BITS-1:0] a,
                           logic [ofl_pkg::BLOCK_BITS-1:0] b,
                           logic [ofl_pkg::STATUS_BITS-1:0] s);
    list_req_t w;
    w.action = a;
    w.blk    = b;
    w.sts    = s;
    pending_words.push_back(w);
  endtask

  // sender stops until every owed result is back, then lets the block settle
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || owed_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // only called with the block idle
  task automatic write_delayed_code(logic [ofl_pkg::STATUS_BITS-1:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    shadow_delayed_code = v;
    n_cfg_writes++;
    @(negedge clk);
  endtask

  // keys mostly from a small pool so deletes and lookups hit
  task automatic queue_burst(int n, int ins_pct, int del_pct);
    int k;
    int r;
    logic [ofl_pkg::ACTION_BITS-1:0] a;
    logic [ofl_pkg::BLOCK_BITS-1:0]  b;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < ins_pct) a = ofl_pkg::ACT_INSERT;
      else if (r < ins_pct + del_pct) a = ofl_pkg::ACT_DELETE;
      else if (r < 95) a = ofl_pkg::ACT_LOOKUP;
      else a = ACT_UNUSED;
      if ($urandom_range(99) < 85) b = key_pool[$urandom_range(POOL_SIZE - 1)];
      else b = ofl_pkg::BLOCK_BITS'($urandom_range((1 << ofl_pkg::BLOCK_BITS) - 1));
      push_word(a, b,
                ofl_pkg::STATUS_BITS'($urandom_range((1 << ofl_pkg::STATUS_BITS) - 1)));
    end
  endtask

  // sequencer
  initial begin : sequence_proc
    int p;
    int j;
    logic [ofl_pkg::STATUS_BITS-1:0] code;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed words under the reset value of delayed_code
    push_word(ofl_pkg::ACT_LOOKUP, '0, '0);          // lookup on empty list
    push_word(ofl_pkg::ACT_DELETE, '1, '1);          // delete on empty list
    push_word(ACT_UNUSED, '1, '1);                   // unused action on empty list
    push_word(ofl_pkg::ACT_INSERT, '1, 3'd1);        // delayed status at the head
    push_word(ofl_pkg::ACT_INSERT, '0, 3'd0);
    push_word(ofl_pkg::ACT_INSERT, '1, '1);          // duplicate insert is appended
    push_word(ofl_pkg::ACT_LOOKUP, '1, '0);
    push_word(ofl_pkg::ACT_DELETE, '1, '0);          // only the first copy goes
    push_word(ofl_pkg::ACT_DELETE, 10'd555, '0);     // delete with no match
    push_word(ACT_UNUSED, '0, '1);                   // unused action on a match
    for (j = 0; j < ofl_pkg::LIST_DEPTH - 2; j++)
      push_word(ofl_pkg::ACT_INSERT, ofl_pkg::BLOCK_BITS'(j * 73 + 1),
                ofl_pkg::STATUS_BITS'(j));
    push_word(ofl_pkg::ACT_INSERT, 10'h2aa, 3'd5);   // insert into a full list
    wait_drained();

    for (p = 0; p < NUM_PHASES; p++) begin
      // extremes of delayed_code in the first two phases and the last, random ones between
      if (p == 0) code = '0;
      else if (p == 1) code = '1;
      else if (p == NUM_PHASES - 1) code = '0;
      else code = ofl_pkg::STATUS_BITS'($urandom_range((1 << ofl_pkg::STATUS_BITS) - 1));
      write_delayed_code(code);

      for (j = 0; j < POOL_SIZE; j++)
        key_pool[j] = ofl_pkg::BLOCK_BITS'($urandom_range((1 << ofl_pkg::BLOCK_BITS) - 1));
      key_pool[0] = (p % 2) ? '1 : '0;

      // receiver holds off while the sender keeps going flat out
      if (p == 2) begin
        idle_pct = 0;
        hold_seq = hold_seq + 1;
      end
      // no idling on either side for a whole phase
      if (p == 4) idle_pct = 0;

      for (j = 0; j < BURSTS; j++) begin
        // alternate filling to overflow and draining towards empty
        if (j % 2 == 0) queue_burst(BURST_LEN, 65, 15);
        else queue_burst(BURST_LEN, 25, 50);
        if (j == 1) wait_drained();   // mid-phase pause of the sender
      end
      wait_drained();
      idle_pct = IDLE_PCT_NORMAL;
    end

    $display("summary: %0d words driven, %0d result words checked, %0d overflows",
             n_words_in, n_results, n_overflow);
    $display("summary: %0d delete hits, %0d delayed_code writes", n_delete_hits,
             n_cfg_writes);
    if (err_cnt == 0 && owed_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog_proc
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
